FILE: hw/rtl/mtdtmf_pkg.sv
package mtdtmf_pkg;

	localparam int SINE_TABLE_DEPTH = 256;
	localparam int PHASE_WIDTH      = 16;
	localparam int COUNT_WIDTH      = 16;
	localparam int ADDR_W           = $clog2(SINE_TABLE_DEPTH);
	localparam int SAMPLE_W         = 17;
	localparam int CHAR_W           = 8;
	localparam int CFG_INDEX_W      = 3;
	localparam int CFG_DATA_W       = 64;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	localparam logic [CFG_INDEX_W-1:0] REG_LOW_STEPS  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HIGH_STEPS = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TONE_LEN   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SHORT_GAP  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_LETTER_GAP = 3'd5;

	localparam logic [14:0] AMPLITUDE_RST  = 15'd16384;
	localparam logic [15:0] TONE_LEN_RST   = 16'd4000;
	localparam logic [15:0] SHORT_GAP_RST  = 16'd400;
	localparam logic [15:0] LETTER_GAP_RST = 16'd4000;

	typedef struct packed {
		logic [47:0] low_steps;
		logic [63:0] high_steps;
		logic [14:0] amplitude;
		logic [15:0] tone_len;
		logic [15:0] short_gap;
		logic [15:0] letter_gap;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sum;
		logic                       active;
		logic                       done;
		logic                       rejected;
	} seq_res_t;

	typedef logic signed [15:0] sine_rom_t [SINE_TABLE_DEPTH];

	// Fifth-order polynomial sine approximation in Q1.15, evaluated once at elaboration.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		longint    p;
		longint    z;
		longint    m;
		longint    z2;
		longint    t1;
		longint    t2;
		longint    r;
		bit        neg;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			p = (longint'(i) * 131072) / SINE_TABLE_DEPTH;
			if (p <= 32768) begin
				z = p;
			end else if (p < 98304) begin
				z = 65536 - p;
			end else begin
				z = p - 131072;
			end
			neg = (z < 0);
			m   = neg ? -z : z;
			z2  = (m * m) >>> 15;
			t1  = 42047 - ((z2 * 4640) >>> 15);
			t2  = 102944 - ((z2 * t1) >>> 15);
			r   = (m * t2) >>> 16;
			if (r > 32767) begin
				r = 32767;
			end
			rom[i] = 16'(neg ? -r : r);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	function automatic logic [COUNT_WIDTH-1:0] sat_len(input logic [15:0] len);
		logic [23:0] wide;
		wide = 24'(len);
		if (wide > 24'(COUNT_MAX)) begin
			return COUNT_MAX;
		end
		return COUNT_WIDTH'(wide);
	endfunction

endpackage

FILE: hw/rtl/mtdtmf_seq.sv
module mtdtmf_seq import mtdtmf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              action,
	input  logic [CHAR_W-1:0] char_code,
	input  cfg_t              cfg,
	output seq_res_t          res
);

	typedef enum logic [1:0] {
		KIND_IDLE,
		KIND_TONE,
		KIND_SHORT,
		KIND_LETTER
	} kind_t;

	kind_t                  kind_q, kind_d;
	logic [3:0]             key_q, key_d;
	logic [2:0]             presses_q, presses_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d;
	logic [PHASE_WIDTH-1:0] low_phase_q, low_phase_d;
	logic [PHASE_WIDTH-1:0] high_phase_q, high_phase_d;

	logic [3:0]             map_key;
	logic [2:0]             map_presses;
	logic [1:0]             lo_sel;
	logic [1:0]             hi_sel;
	logic [PHASE_WIDTH-1:0] lo_step;
	logic [PHASE_WIDTH-1:0] hi_step;
	logic [ADDR_W-1:0]      lo_addr;
	logic [ADDR_W-1:0]      hi_addr;
	logic signed [SAMPLE_W-1:0] sine_sum;
	logic [COUNT_WIDTH-1:0] count_inc;
	logic [COUNT_WIDTH-1:0] tone_len;
	logic [COUNT_WIDTH-1:0] short_len;
	logic [COUNT_WIDTH-1:0] letter_len;
	logic [2:0]             presses_dec;

	// Multi-tap keypad: digits take one press, letters two to five.
	always_comb begin
		map_key     = 4'd0;
		map_presses = 3'd0;
		if (char_code >= "1" && char_code <= "9") begin
			map_key     = 4'(char_code - "1");
			map_presses = 3'd1;
		end else if (char_code == "0") begin
			map_key     = 4'd10;
			map_presses = 3'd1;
		end else if (char_code >= "a" && char_code <= "c") begin
			map_key     = 4'd1;
			map_presses = 3'(char_code - "a" + 8'd2);
		end else if (char_code >= "d" && char_code <= "f") begin
			map_key     = 4'd2;
			map_presses = 3'(char_code - "d" + 8'd2);
		end else if (char_code >= "g" && char_code <= "i") begin
			map_key     = 4'd3;
			map_presses = 3'(char_code - "g" + 8'd2);
		end else if (char_code >= "j" && char_code <= "l") begin
			map_key     = 4'd4;
			map_presses = 3'(char_code - "j" + 8'd2);
		end else if (char_code >= "m" && char_code <= "o") begin
			map_key     = 4'd5;
			map_presses = 3'(char_code - "m" + 8'd2);
		end else if (char_code >= "p" && char_code <= "r") begin
			map_key     = 4'd6;
			map_presses = 3'(char_code - "p" + 8'd2);
		end else if (char_code == "s") begin
			map_key     = 4'd6;
			map_presses = 3'd5;
		end else if (char_code >= "t" && char_code <= "v") begin
			map_key     = 4'd7;
			map_presses = 3'(char_code - "t" + 8'd2);
		end else if (char_code >= "w" && char_code <= "y") begin
			map_key     = 4'd8;
			map_presses = 3'(char_code - "w" + 8'd2);
		end else if (char_code == "z") begin
			map_key     = 4'd8;
			map_presses = 3'd5;
		end else if (char_code == ".") begin
			map_key     = 4'd9;
			map_presses = 3'd2;
		end else if (char_code == "!") begin
			map_key     = 4'd9;
			map_presses = 3'd3;
		end else if (char_code == "?") begin
			map_key     = 4'd9;
			map_presses = 3'd4;
		end else if (char_code == "#") begin
			map_key     = 4'd9;
			map_presses = 3'd1;
		end else if (char_code == " ") begin
			map_key     = 4'd10;
			map_presses = 3'd2;
		end
	end

	// Key codes above ten wrap round modulo eleven.
	always_comb begin
		case (key_q)
			4'd0, 4'd11: begin lo_sel = 2'd0; hi_sel = 2'd0; end
			4'd1, 4'd12: begin lo_sel = 2'd1; hi_sel = 2'd0; end
			4'd2, 4'd13: begin lo_sel = 2'd2; hi_sel = 2'd0; end
			4'd3, 4'd14: begin lo_sel = 2'd0; hi_sel = 2'd1; end
			4'd4, 4'd15: begin lo_sel = 2'd1; hi_sel = 2'd1; end
			4'd5:        begin lo_sel = 2'd2; hi_sel = 2'd1; end
			4'd6:        begin lo_sel = 2'd0; hi_sel = 2'd2; end
			4'd7:        begin lo_sel = 2'd1; hi_sel = 2'd2; end
			4'd8:        begin lo_sel = 2'd2; hi_sel = 2'd2; end
			4'd9:        begin lo_sel = 2'd0; hi_sel = 2'd3; end
			4'd10:       begin lo_sel = 2'd1; hi_sel = 2'd3; end
			default:     begin lo_sel = 2'd0; hi_sel = 2'd0; end
		endcase
	end

	assign lo_step = cfg.low_steps[{lo_sel, 4'b0000} +: PHASE_WIDTH];
	assign hi_step = cfg.high_steps[{hi_sel, 4'b0000} +: PHASE_WIDTH];

	assign lo_addr = ADDR_W'(((PHASE_WIDTH + ADDR_W)'(low_phase_q) * SINE_TABLE_DEPTH)
		>> PHASE_WIDTH);
	assign hi_addr = ADDR_W'(((PHASE_WIDTH + ADDR_W)'(high_phase_q) * SINE_TABLE_DEPTH)
		>> PHASE_WIDTH);
	assign sine_sum = SAMPLE_W'(SINE_ROM[lo_addr]) + SAMPLE_W'(SINE_ROM[hi_addr]);

	assign count_inc   = count_q + 1'b1;
	assign short_len   = sat_len(cfg.short_gap);
	assign letter_len  = sat_len(cfg.letter_gap);
	assign tone_len    = (sat_len(cfg.tone_len) == '0) ? COUNT_WIDTH'(1) : sat_len(cfg.tone_len);
	assign presses_dec = (presses_q != 3'd0) ? presses_q - 3'd1 : 3'd0;

	always_comb begin
		kind_d       = kind_q;
		key_d        = key_q;
		presses_d    = presses_q;
		count_d      = count_q;
		low_phase_d  = low_phase_q;
		high_phase_d = high_phase_q;
		res          = '0;
		if (!action) begin
			if (kind_q != KIND_IDLE || map_presses == 3'd0) begin
				res.rejected = 1'b1;
			end else begin
				key_d        = map_key;
				presses_d    = map_presses;
				kind_d       = KIND_TONE;
				count_d      = '0;
				low_phase_d  = '0;
				high_phase_d = '0;
			end
			res.active = (kind_d != KIND_IDLE);
		end else begin
			case (kind_q)
				KIND_TONE: begin
					res.sum      = sine_sum;
					res.active   = 1'b1;
					low_phase_d  = low_phase_q + lo_step;
					high_phase_d = high_phase_q + hi_step;
					count_d      = count_inc;
					if (count_inc >= tone_len) begin
						presses_d = presses_dec;
						count_d   = '0;
						if (presses_dec != 3'd0) begin
							if (short_len == '0) begin
								low_phase_d  = '0;
								high_phase_d = '0;
							end else begin
								kind_d = KIND_SHORT;
							end
						end else if (letter_len == '0) begin
							kind_d   = KIND_IDLE;
							res.done = 1'b1;
						end else begin
							kind_d = KIND_LETTER;
						end
					end
				end
				KIND_SHORT: begin
					res.active = 1'b1;
					count_d    = count_inc;
					if (count_inc >= short_len) begin
						kind_d       = KIND_TONE;
						count_d      = '0;
						low_phase_d  = '0;
						high_phase_d = '0;
					end
				end
				KIND_LETTER: begin
					res.active = 1'b1;
					count_d    = count_inc;
					if (count_inc >= letter_len) begin
						kind_d   = KIND_IDLE;
						count_d  = '0;
						res.done = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q       <= KIND_IDLE;
			key_q        <= '0;
			presses_q    <= '0;
			count_q      <= '0;
			low_phase_q  <= '0;
			high_phase_q <= '0;
		end else if (fire) begin
			kind_q       <= kind_d;
			key_q        <= key_d;
			presses_q    <= presses_d;
			count_q      <= count_d;
			low_phase_q  <= low_phase_d;
			high_phase_q <= high_phase_d;
		end
	end

endmodule

FILE: hw/rtl/multitap_dtmf_tone_generator.sv
// Multi-tap DTMF tone generator.
// Input transactions arrive on the s_ group. s_tuser selects the action: 0 loads
// the ASCII character in s_tdata, 1 requests one audio sample. Every input
// transaction yields exactly one output transaction on the m_ group, in order.
// m_tdata carries the signed sample, the active flag and the rejected flag;
// m_tlast marks the last sample of a character: the end of its letter gap or,
// with no letter gap, of its last tone. A character is refused while another is still playing or when it is not on
// the keypad. Registers are written on the cfg_ group and are accepted in
// every cycle; they should only be changed while no transaction is in flight.
// After its input transaction is accepted the result passes
// through three registers: input, sequencer result with table lookup and sine
// sum, then the amplitude multiply into the output register. One
// transaction is accepted in every cycle while m_tready does not stall the pipeline;
// the rate is bounded by the sequencer state update.
// When m_tready is held low the three stages fill up and s_tready then falls;
// empty stages are filled even while the output waits.
// Reset clears the pipeline, makes the sequencer idle with both phases at zero
// and loads the default registers: all steps zero, amplitude one half, tone
// and letter gap 4000 samples, short gap 400 samples.
module multitap_dtmf_tone_generator import mtdtmf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [7:0] character_code
	input  logic                   s_tuser,   // [0] action
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [23:0]            m_tdata,   // [16:0] sample, [17] active, [18] rejected
	output logic                   m_tlast,   // character_done
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t                cfg_q;
	logic                valid_s1;
	logic                action_s1;
	logic [CHAR_W-1:0]   char_s1;
	logic                valid_s2;
	seq_res_t            res_s2;
	seq_res_t            seq_res;
	logic                m_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                active_q;
	logic                done_q;
	logic                rejected_q;
	logic                out_free;
	logic                s2_ready;
	logic                s1_ready;
	logic                fire;
	logic [SAMPLE_W-1:0] mag;
	logic [32:0]         prod;
	logic [SAMPLE_W-1:0] scaled;
	logic signed [SAMPLE_W-1:0] sample_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_steps  <= '0;
			cfg_q.high_steps <= '0;
			cfg_q.amplitude  <= AMPLITUDE_RST;
			cfg_q.tone_len   <= TONE_LEN_RST;
			cfg_q.short_gap  <= SHORT_GAP_RST;
			cfg_q.letter_gap <= LETTER_GAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOW_STEPS:  cfg_q.low_steps  <= cfg_data[47:0];
				REG_HIGH_STEPS: cfg_q.high_steps <= cfg_data;
				REG_AMPLITUDE:  cfg_q.amplitude  <= cfg_data[14:0];
				REG_TONE_LEN:   cfg_q.tone_len   <= cfg_data[15:0];
				REG_SHORT_GAP:  cfg_q.short_gap  <= cfg_data[15:0];
				REG_LETTER_GAP: cfg_q.letter_gap <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign out_free = !m_valid_q || m_tready;
	assign s2_ready = !valid_s2 || out_free;
	assign s1_ready = !valid_s1 || s2_ready;
	assign s_tready = s1_ready;
	assign fire     = valid_s1 && s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s1_ready) begin
			action_s1 <= s_tuser;
			char_s1   <= s_tdata;
		end
	end

	mtdtmf_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.action    (action_s1),
		.char_code (char_s1),
		.cfg       (cfg_q),
		.res       (seq_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= seq_res;
		end
	end

	// Scale the magnitude and round half away from zero.
	assign mag      = res_s2.sum[SAMPLE_W-1] ? SAMPLE_W'(-res_s2.sum) : SAMPLE_W'(res_s2.sum);
	assign prod     = 33'(cfg_q.amplitude) * 33'(mag) + 33'd16384;
	assign scaled   = prod[15 +: SAMPLE_W];
	assign sample_d = res_s2.sum[SAMPLE_W-1] ? -$signed(scaled) : $signed(scaled);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && out_free) begin
			sample_q   <= sample_d;
			active_q   <= res_s2.active;
			done_q     <= res_s2.done;
			rejected_q <= res_s2.rejected;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'd0, rejected_q, active_q, sample_q};
	assign m_tlast  = done_q;

	a_done_not_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(done_q && rejected_q))
		else $error("character end and refusal in one transaction");

	a_sound_only_active: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && sample_q != '0) |-> (active_q && !rejected_q))
		else $error("non-zero sample outside a playing character");

	a_done_while_active: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && done_q) |-> active_q)
		else $error("character end without activity");

	a_fire_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("sequencer advanced without a following stage entry");

endmodule

FILE: test/tb_multitap_dtmf_tone_generator.sv
import mtdtmf_pkg::*;

typedef enum logic [1:0] {SEG_IDLE, SEG_TONE, SEG_SHORT_GAP, SEG_LETTER_GAP} segment_t;

class tone_checker;
	seq_res_t               expected_samples[$];
	int                     errors;
	cfg_t                   regs;
	logic [3:0]             key_index;
	logic [2:0]             presses_left;
	segment_t               segment;
	int                     segment_count;
	logic [PHASE_WIDTH-1:0] low_phase;
	logic [PHASE_WIDTH-1:0] high_phase;
	int                     sine_table[SINE_TABLE_DEPTH];

	function new();
		longint angle;
		longint folded;
		longint mag;
		longint sq;
		longint c1;
		longint c2;
		longint r;
		errors = 0;
		regs = '0;
		regs.amplitude = AMPLITUDE_RST;
		regs.tone_len = TONE_LEN_RST;
		regs.short_gap = SHORT_GAP_RST;
		regs.letter_gap = LETTER_GAP_RST;
		key_index = '0;
		presses_left = '0;
		segment = SEG_IDLE;
		segment_count = 0;
		low_phase = '0;
		high_phase = '0;
		// The angle is in Q15 quarter turns and is folded into one quarter turn either side of zero.
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			angle = (longint'(i) * 131072) / SINE_TABLE_DEPTH;
			if (angle <= 32768) begin
				folded = angle;
			end else if (angle < 98304) begin
				folded = 65536 - angle;
			end else begin
				folded = angle - 131072;
			end
			mag = (folded < 0) ? -folded : folded;
			sq = (mag * mag) >> 15;
			c1 = 42047 - ((sq * 4640) >> 15);
			c2 = 102944 - ((sq * c1) >> 15);
			r = (mag * c2) >> 16;
			if (r > 32767) begin
				r = 32767;
			end
			sine_table[i] = (folded < 0) ? -int'(r) : int'(r);
		end
	endfunction

	function int clamp_length(input logic [15:0] len);
		longint limit;
		limit = (longint'(1) << COUNT_WIDTH) - 1;
		return (len > limit) ? int'(limit) : int'(len);
	endfunction

	function int key_presses(input logic [7:0] c, output logic [3:0] key);
		int code;
		code = c;
		key = '0;
		if (code >= "1" && code <= "9") begin
			key = 4'(code - "1");
			return 1;
		end
		if (code == "0") begin
			key = 4'd10;
			return 1;
		end
		if (code >= "a" && code <= "r") begin
			key = 4'((code - "a") / 3 + 1);
			return (code - "a") % 3 + 2;
		end
		if (code == "s") begin
			key = 4'd6;
			return 5;
		end
		if (code >= "t" && code <= "y") begin
			key = 4'((code - "a" - 1) / 3 + 1);
			return (code - "a" - 1) % 3 + 2;
		end
		if (code == "z") begin
			key = 4'd8;
			return 5;
		end
		key = 4'd9;
		case (code)
			".": return 2;
			"!": return 3;
			"?": return 4;
			"#": return 1;
			" ": begin
				key = 4'd10;
				return 2;
			end
			default: begin
				key = '0;
				return 0;
			end
		endcase
	endfunction

	function void begin_tone();
		segment = SEG_TONE;
		segment_count = 0;
		low_phase = '0;
		high_phase = '0;
	endfunction

	function seq_res_t next_sample(input logic act, input logic [7:0] c);
		seq_res_t               r;
		logic [3:0]             key;
		int                     presses;
		int                     k;
		int                     len;
		int                     lo_idx;
		int                     hi_idx;
		logic [PHASE_WIDTH-1:0] lo_step;
		logic [PHASE_WIDTH-1:0] hi_step;
		longint                 s;
		longint                 scaled;
		r = '0;
		if (!act) begin
			presses = key_presses(c, key);
			if (segment != SEG_IDLE || presses == 0) begin
				r.rejected = 1'b1;
			end else begin
				key_index = key;
				presses_left = 3'(presses);
				begin_tone();
			end
			r.active = (segment != SEG_IDLE);
		end else begin
			case (segment)
				SEG_TONE: begin
					k = key_index % 11;
					lo_step = PHASE_WIDTH'(regs.low_steps >> (16 * (k % 3)));
					hi_step = PHASE_WIDTH'(regs.high_steps >> (16 * (k / 3)));
					lo_idx = int'((longint'(low_phase) * SINE_TABLE_DEPTH) >> PHASE_WIDTH);
					hi_idx = int'((longint'(high_phase) * SINE_TABLE_DEPTH) >> PHASE_WIDTH);
					s = longint'(sine_table[lo_idx]) + longint'(sine_table[hi_idx]);
					scaled = (longint'(regs.amplitude) * ((s < 0) ? -s : s) + 16384) >> 15;
					r.sum = SAMPLE_W'((s < 0) ? -scaled : scaled);
					low_phase = low_phase + lo_step;
					high_phase = high_phase + hi_step;
					r.active = 1'b1;
					segment_count++;
					len = clamp_length(regs.tone_len);
					if (len == 0) begin
						len = 1;
					end
					if (segment_count >= len) begin
						if (presses_left > 0) begin
							presses_left--;
						end
						segment_count = 0;
						if (presses_left > 0) begin
							if (clamp_length(regs.short_gap) == 0) begin
								begin_tone();
							end else begin
								segment = SEG_SHORT_GAP;
							end
						end else if (clamp_length(regs.letter_gap) == 0) begin
							segment = SEG_IDLE;
							r.done = 1'b1;
						end else begin
							segment = SEG_LETTER_GAP;
						end
					end
				end
				SEG_SHORT_GAP: begin
					r.active = 1'b1;
					segment_count++;
					if (segment_count >= clamp_length(regs.short_gap)) begin
						begin_tone();
					end
				end
				SEG_LETTER_GAP: begin
					r.active = 1'b1;
					segment_count++;
					if (segment_count >= clamp_length(regs.letter_gap)) begin
						segment = SEG_IDLE;
						segment_count = 0;
						r.done = 1'b1;
					end
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	function void write_register(input logic [CFG_INDEX_W-1:0] index, input logic [63:0] data);
		case (index)
			REG_LOW_STEPS:  regs.low_steps = data[47:0];
			REG_HIGH_STEPS: regs.high_steps = data;
			REG_AMPLITUDE:  regs.amplitude = data[14:0];
			REG_TONE_LEN:   regs.tone_len = data[15:0];
			REG_SHORT_GAP:  regs.short_gap = data[15:0];
			REG_LETTER_GAP: regs.letter_gap = data[15:0];
			default: ;
		endcase
	endfunction

	function void note_input(input logic act, input logic [7:0] c);
		expected_samples.push_back(next_sample(act, c));
	endfunction

	function void compare_field(input string name, input logic signed [17:0] want,
			input logic signed [17:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	function void check_sample(input logic [23:0] data, input logic last);
		seq_res_t want;
		if (expected_samples.size() == 0) begin
			errors++;
			$display("%0t: sample with nothing outstanding, expected none, actual tdata %h tlast %b",
				$time, data, last);
			return;
		end
		want = expected_samples.pop_front();
		compare_field("sample", want.sum, $signed(data[16:0]));
		compare_field("active", want.active, data[17]);
		compare_field("rejected", want.rejected, data[18]);
		compare_field("character_done", want.done, last);
	endfunction

	function int pending();
		return expected_samples.size();
	endfunction

	function bit idle();
		return segment == SEG_IDLE;
	endfunction
endclass

module tb_multitap_dtmf_tone_generator;
	localparam int CYCLE_LIMIT  = 5_000_000;
	localparam int RANDOM_ITEMS = 620;

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [23:0]            m_tdata;
	logic                   m_tlast;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	tone_checker tones = new();
	string       keypad_chars = "0123456789abcdefghijklmnopqrstuvwxyz.!?# ";
	int          cycle_count = 0;
	int          item_count = 0;
	int          burst_left = 0;
	int          stall_run = 0;
	rx_mode_t    stall_mode = RX_ALWAYS;
	logic [15:0] stall_pattern = 16'hffff;

	multitap_dtmf_tone_generator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				tones.note_input(s_tuser, s_tdata);
				item_count++;
			end
			if (m_tvalid && m_tready) begin
				tones.check_sample(m_tdata, m_tlast);
			end
		end
	end

	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_mode = rx_mode_t'($urandom_range(0, 2));
			stall_run = $urandom_range(16, 160);
			stall_pattern = 16'($urandom);
		end
		stall_run--;
		case (stall_mode)
			RX_ALWAYS: m_tready = 1'b1;
			RX_RANDOM: m_tready = ($urandom_range(0, 2) != 0);
			default: begin
				m_tready = stall_pattern[0];
				stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
			end
		endcase
	end

	task automatic send_item(input logic act, input logic [7:0] code);
		s_tuser = act;
		s_tdata = code;
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
				: $urandom_range(0, 8);
		end
	endtask

	task automatic tick();
		send_item(1'b1, 8'($urandom));
	endtask

	task automatic play_char(input logic [7:0] code, input bit noisy);
		send_item(1'b0, code);
		while (!tones.idle()) begin
			if (noisy && $urandom_range(0, 15) == 0) begin
				send_item(1'b0, 8'($urandom));
			end else begin
				tick();
			end
		end
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (tones.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic configure(input logic [CFG_INDEX_W-1:0] index, input logic [63:0] data);
		cfg_index = index;
		cfg_data = data;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tones.write_register(index, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [63:0] with_noise(input logic [15:0] value, input int bits);
		return ({$urandom, $urandom} << bits) | 64'(value);
	endfunction

	task automatic program_phase(input logic [14:0] amp, input logic [15:0] tone_len,
			input logic [15:0] short_gap, input logic [15:0] letter_gap);
		drain();
		configure(REG_LOW_STEPS, {$urandom, $urandom});
		configure(REG_HIGH_STEPS, {$urandom, $urandom});
		configure(REG_AMPLITUDE, with_noise(16'(amp), 15));
		configure(REG_TONE_LEN, with_noise(tone_len, 16));
		configure(REG_SHORT_GAP, with_noise(short_gap, 16));
		configure(REG_LETTER_GAP, with_noise(letter_gap, 16));
	endtask

	initial begin
		int target;
		int phase_end;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_LOW_STEPS;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// A tick while idle, invalid characters, then a load while busy at the reset amplitude.
		tick();
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hff);
		drain();
		configure(REG_LOW_STEPS, {$urandom, $urandom});
		configure(REG_HIGH_STEPS, {$urandom, $urandom});
		configure(REG_TONE_LEN, with_noise(16'd6, 16));
		configure(REG_SHORT_GAP, with_noise(16'd3, 16));
		configure(REG_LETTER_GAP, with_noise(16'd5, 16));
		send_item(1'b0, "1");
		send_item(1'b0, "a");
		while (!tones.idle()) tick();
		tick();

		program_phase(15'h7fff, 16'd3, 16'd0, 16'd0);
		play_char("s", 1'b0);
		play_char("z", 1'b0);
		play_char("0", 1'b0);

		program_phase(15'd0, 16'd0, 16'd2, 16'd1);
		play_char("?", 1'b0);
		play_char("#", 1'b0);
		play_char("!", 1'b0);
		play_char(" ", 1'b0);

		program_phase(15'h7fff, 16'd40, 16'd30, 16'd40);
		play_char("#", 1'b0);

		program_phase(15'd1, 16'd1, 16'd60, 16'd0);
		play_char(".", 1'b0);

		target = item_count + RANDOM_ITEMS;
		while (item_count < target) begin
			program_phase(($urandom_range(0, 3) == 0) ? 15'h7fff : 15'($urandom),
				16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 5)),
				16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 4)),
				16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 5)));
			phase_end = item_count + $urandom_range(60, 160);
			while (item_count < phase_end && item_count < target) begin
				case ($urandom_range(0, 9))
					7: send_item(1'b0, 8'($urandom));
					8, 9: repeat ($urandom_range(1, 3)) tick();
					default: play_char(keypad_chars[$urandom_range(0, keypad_chars.len() - 1)], 1'b1);
				endcase
			end
		end

		drain();
		if (tones.errors == 0 && tones.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
